### rtl/cpr_pkg.sv
package cpr_pkg;

    localparam int BUF_DEPTH_DEF     = 4096;
    localparam int PIO_THRESHOLD_DEF = 16;
    localparam int SCNT_W            = 19;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_PIO   = 2'd2,
        REQ_DRAIN = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind   kind;
        logic [4:0]  index;
        logic [7:0]  data;
    } t_req;

    typedef struct packed {
        logic irq;
        logic int_flag;
        logic ready;
    } t_status;

    localparam logic [4:0] REG_FORMAT   = 5'd8;
    localparam logic [4:0] REG_CONFIG   = 5'd9;
    localparam logic [4:0] REG_PIN_CTRL = 5'd10;
    localparam logic [4:0] REG_TEST     = 5'd11;
    localparam logic [4:0] REG_MODE     = 5'd12;
    localparam logic [4:0] REG_BASE_HI  = 5'd14;
    localparam logic [4:0] REG_BASE_LO  = 5'd15;
    localparam logic [4:0] REG_STATUS   = 5'd24;
    localparam logic [4:0] REG_VERSION  = 5'd25;

    localparam logic [7:0] B_PEN   = 8'h01;
    localparam logic [7:0] B_CEN   = 8'h02;
    localparam logic [7:0] B_PPIO  = 8'h40;
    localparam logic [7:0] B_IEN   = 8'h02;
    localparam logic [7:0] B_PI    = 8'h10;
    localparam logic [7:0] B_CI    = 8'h20;
    localparam logic [7:0] B_TI    = 8'h40;

    localparam logic [7:0] STATUS_KEEP = 8'h0f;
    localparam logic [7:0] MODE_MASK   = 8'h40;
    localparam logic [7:0] MODE_FIXED  = 8'h8a;
    localparam logic [2:0] FMT_ADPCM   = 3'b101;
    localparam logic [2:0] FMT_16_LE   = 3'b010;
    localparam logic [2:0] FMT_16_BE   = 3'b110;

endpackage

### rtl/cpr_in_reg.sv
module cpr_in_reg
    import cpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_req,
    input  logic       i_advance,
    output logic       o_req_valid,
    output t_req       o_req
);

    logic r_valid;
    t_req r_req;

    assign o_ready     = !r_valid || i_advance;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

### rtl/cpr_fifo_ram.sv
module cpr_fifo_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### rtl/cpr_ctrl.sv
module cpr_ctrl
    import cpr_pkg::*;
#(
    parameter int BUF_DEPTH     = BUF_DEPTH_DEF,
    parameter int PIO_THRESHOLD = PIO_THRESHOLD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_irq_present,
    input  logic                         i_req_valid,
    input  t_req                         i_req,
    output logic                         o_advance,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_read_data,
    output logic                         o_drain_valid,
    output t_status                      o_status,
    output logic [$clog2(BUF_DEPTH+1)-1:0] o_fill
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);

    logic [7:0]        r_regs [32];
    logic [7:0]        n_regs [32];
    logic [AW-1:0]     r_wp, n_wp, r_rp, n_rp;
    logic [FW-1:0]     r_fill, n_fill;
    logic [SCNT_W-1:0] r_scnt, n_scnt;
    t_status           r_st, n_st;

    logic              r_out_valid;
    logic [7:0]        r_rd, n_rd;
    logic              r_hit, n_hit;
    t_status           r_o_st;
    logic [FW-1:0]     r_o_fill;

    logic              proc;
    logic              mem_we, mem_re;
    logic [7:0]        ram_q;
    logic [7:0]        old_val, keep, nv, cleared, wv, chg;
    logic [AW:0]       aligned;
    logic [1:0]        step;
    logic [SCNT_W-1:0] scnt_inc, period;
    logic [1:0]        shift;
    logic [2:0]        fmt_top;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(BUF_DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign o_advance     = !r_out_valid || i_ready;
    assign proc          = i_req_valid && o_advance;
    assign o_valid       = r_out_valid;
    assign o_read_data   = r_hit ? ram_q : r_rd;
    assign o_drain_valid = r_hit;
    assign o_status      = r_o_st;
    assign o_fill        = r_o_fill;

    assign old_val = r_regs[i_req.index];
    assign fmt_top = r_regs[REG_FORMAT][7:5];
    assign scnt_inc = r_scnt + SCNT_W'(1);
    assign step    = 2'(~r_wp[1:0] + 2'd1);

    always_comb begin
        if (fmt_top == FMT_ADPCM) begin
            shift = 2'd2;
        end else begin
            shift = 2'(fmt_top == FMT_16_LE || fmt_top == FMT_16_BE)
                  + 2'(r_regs[REG_FORMAT][4]);
        end
        period = (SCNT_W'({r_regs[REG_BASE_HI], r_regs[REG_BASE_LO]}) + SCNT_W'(1))
                 << shift;
    end

    always_comb begin
        aligned = {1'b0, r_wp} + (AW+1)'(step);
        if (aligned >= (AW+1)'(BUF_DEPTH)) begin
            aligned = aligned - (AW+1)'(BUF_DEPTH);
        end
    end

    assign keep    = i_req.data | STATUS_KEEP;
    assign nv      = old_val & keep;
    assign cleared = old_val & ~keep;
    assign wv      = (i_req.index == REG_MODE) ? ((i_req.data & MODE_MASK) | MODE_FIXED)
                                               : i_req.data;
    assign chg     = old_val ^ wv;

    always_comb begin
        n_regs = r_regs;
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_fill = r_fill;
        n_scnt = r_scnt;
        n_st   = r_st;
        n_rd   = '0;
        n_hit  = 1'b0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        if (proc) begin
            unique case (i_req.kind)
                REQ_WRITE: begin
                    if (i_req.index == REG_STATUS) begin
                        n_regs[REG_STATUS] = nv;
                        if ((cleared & (B_PI | B_TI | B_CI)) != 8'd0
                            && (nv & (B_PI | B_TI | B_CI)) == 8'd0) begin
                            n_st.irq      = 1'b0;
                            n_st.int_flag = 1'b0;
                        end
                    end else if (i_req.index != REG_TEST && i_req.index != REG_VERSION) begin
                        n_regs[i_req.index] = wv;
                        if (i_req.index == REG_FORMAT && chg[7:4] != 4'd0) begin
                            n_wp   = aligned[AW-1:0];
                            n_rp   = aligned[AW-1:0];
                            n_fill = '0;
                        end
                        if (i_req.index == REG_CONFIG && (chg & (B_PEN | B_CEN)) != 8'd0
                            && (wv & (B_PEN | B_CEN)) != 8'd0) begin
                            n_scnt = '0;
                        end
                    end
                end
                REQ_READ: begin
                    n_rd = old_val;
                end
                REQ_PIO: begin
                    if ((r_regs[REG_CONFIG] & B_PPIO) != 8'd0) begin
                        if (r_fill < FW'(BUF_DEPTH)) begin
                            mem_we = 1'b1;
                            n_fill = r_fill + FW'(1);
                            n_wp   = ptr_inc(r_wp);
                        end
                        n_st.ready = (32'(n_fill) <= 32'(PIO_THRESHOLD));
                        if ((r_regs[REG_CONFIG] & B_PEN) != 8'd0) begin
                            if (scnt_inc >= period) begin
                                n_scnt             = '0;
                                n_regs[REG_STATUS] = r_regs[REG_STATUS] | B_PI;
                                n_st.int_flag      = 1'b1;
                                if ((r_regs[REG_PIN_CTRL] & B_IEN) != 8'd0 && i_irq_present) begin
                                    n_st.irq = 1'b1;
                                end
                            end else begin
                                n_scnt = scnt_inc;
                            end
                        end
                    end
                end
                REQ_DRAIN: begin
                    if (r_fill != '0) begin
                        mem_re = 1'b1;
                        n_rp   = ptr_inc(r_rp);
                        n_fill = r_fill - FW'(1);
                        n_hit  = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) begin
                r_regs[k] <= '0;
            end
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_scnt      <= '0;
            r_st        <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_regs <= n_regs;
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
            r_scnt <= n_scnt;
            r_st   <= n_st;
            if (o_advance) begin
                r_out_valid <= i_req_valid;
            end
            if (proc) begin
                r_hit <= n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_rd     <= n_rd;
            r_o_st   <= n_st;
            r_o_fill <= n_fill;
        end
    end

    cpr_fifo_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (8)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_req.data),
        .i_re    (mem_re),
        .i_raddr (r_rp),
        .o_rdata (ram_q)
    );

endmodule

### rtl/codec_pio_playback_registers.sv
// Indexed register block of an audio codec with PIO playback: each transaction is a
// register write, a register read, a playback byte pushed into the FIFO, or a drain that
// pops one byte. One transaction is taken every clock cycle while the result side does
// not stall; its result is presented through the input register, then the result register,
// and the drained byte comes straight from the registered read port of the FIFO RAM.
// Backpressure on the result side stalls the input after at most one more transaction.
// The FIFO needs no clearing after reset. i_cfg_we writes irq_present; write it only
// while idle.
module codec_pio_playback_registers
    import cpr_pkg::*;
#(
    parameter int BUF_DEPTH     = BUF_DEPTH_DEF,
    parameter int PIO_THRESHOLD = PIO_THRESHOLD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [4:0]                     i_reg_index,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_read_data,
    output logic                           o_drain_valid,
    output logic                           o_irq_line,
    output logic                           o_int_status,
    output logic                           o_play_ready,
    output logic [$clog2(BUF_DEPTH+1)-1:0] o_buffer_fill
);

    logic    r_irq_present;
    t_req    in_req;
    t_req    req;
    logic    req_valid;
    logic    advance;
    t_status status;

    assign in_req.kind  = t_req_kind'(i_req_type);
    assign in_req.index = i_reg_index;
    assign in_req.data  = i_data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_present <= 1'b0;
        end else if (i_cfg_we) begin
            r_irq_present <= i_cfg_data;
        end
    end

    cpr_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (in_req),
        .i_advance   (advance),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    cpr_ctrl #(
        .BUF_DEPTH     (BUF_DEPTH),
        .PIO_THRESHOLD (PIO_THRESHOLD)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_irq_present (r_irq_present),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_advance     (advance),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_drain_valid (o_drain_valid),
        .o_status      (status),
        .o_fill        (o_buffer_fill)
    );

    assign o_irq_line   = status.irq;
    assign o_int_status = status.int_flag;
    assign o_play_ready = status.ready;

endmodule

### bench/tb_codec_pio_playback_registers.sv
`timescale 1ns / 1ps

module tb_codec_pio_playback_registers;
    import cpr_pkg::*;

    localparam int FILL_W    = $clog2(BUF_DEPTH_DEF + 1);
    localparam int LIMIT     = 1000000;
    localparam int HOLD_AT   = 200;
    localparam int HOLD_LEN  = 400;
    localparam int BURST_LEN = 100;

    typedef struct packed {
        logic [7:0]        rdata;
        logic              dvalid;
        logic              irq;
        logic              intr;
        logic              prdy;
        logic [FILL_W-1:0] fill;
    } t_reply;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_data  = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [1:0]        i_req_type  = 2'd0;
    logic [4:0]        i_reg_index = 5'd0;
    logic [7:0]        i_data_byte = 8'd0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [7:0]        o_read_data;
    logic              o_drain_valid;
    logic              o_irq_line;
    logic              o_int_status;
    logic              o_play_ready;
    logic [FILL_W-1:0] o_buffer_fill;

    codec_pio_playback_registers dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_reg_index   (i_reg_index),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_drain_valid (o_drain_valid),
        .o_irq_line    (o_irq_line),
        .o_int_status  (o_int_status),
        .o_play_ready  (o_play_ready),
        .o_buffer_fill (o_buffer_fill)
    );

    t_req        req_q[$];
    t_reply      reply_q[$];

    logic [7:0]  shadow_regs [32];
    logic [7:0]  shadow_fifo [BUF_DEPTH_DEF];
    int unsigned wr_ptr       = 0;
    int unsigned rd_ptr       = 0;
    int unsigned fill_cnt     = 0;
    int unsigned sample_cnt   = 0;
    bit          int_f        = 1'b0;
    bit          ready_f      = 1'b0;
    bit          irq_f        = 1'b0;
    bit          irq_present_f = 1'b0;

    int unsigned req_cnt      = 0;
    int unsigned reply_cnt    = 0;
    int unsigned drain_cnt    = 0;
    int unsigned period_cnt   = 0;
    int unsigned drop_cnt     = 0;
    int unsigned peak_fill    = 0;
    int unsigned fail_cnt     = 0;
    int unsigned cycle_cnt    = 0;

    bit          in_taken     = 1'b0;
    bit          out_taken    = 1'b0;
    int unsigned tx_wait      = 0;
    int unsigned tx_calm      = 0;
    int unsigned rx_wait      = 0;
    int unsigned rx_calm      = 0;
    int unsigned hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(10, 60);
        return $urandom_range(0, 17);
    endfunction

    function automatic t_reply codec_apply(t_req r);
        logic [7:0]  old;
        logic [7:0]  d;
        logic [7:0]  changed;
        logic [7:0]  keep;
        logic [7:0]  cleared;
        logic [7:0]  nv;
        logic [7:0]  fmt;
        int unsigned bpc;
        int unsigned base;
        int unsigned period;
        t_reply      rep;
        rep = '0;
        case (r.kind)
            REQ_WRITE: begin
                old = shadow_regs[r.index];
                d   = r.data;
                if (r.index == REG_TEST || r.index == REG_VERSION) begin
                end else if (r.index == REG_STATUS) begin
                    keep    = d | STATUS_KEEP;
                    cleared = old & ~keep;
                    nv      = old & keep;
                    shadow_regs[REG_STATUS] = nv;
                    if ((cleared & (B_PI | B_TI | B_CI)) != 0 && (nv & (B_PI | B_TI | B_CI)) == 0) begin
                        irq_f = 1'b0;
                        int_f = 1'b0;
                    end
                end else begin
                    if (r.index == REG_MODE)
                        d = (d & MODE_MASK) | MODE_FIXED;
                    changed = old ^ d;
                    shadow_regs[r.index] = d;
                    if (r.index == REG_FORMAT && changed[7:4] != 0) begin
                        wr_ptr   = ((wr_ptr + 3) & ~32'd3) % BUF_DEPTH_DEF;
                        rd_ptr   = wr_ptr;
                        fill_cnt = 0;
                    end
                    if (r.index == REG_CONFIG && (changed & (B_PEN | B_CEN)) != 0
                        && (d & (B_PEN | B_CEN)) != 0)
                        sample_cnt = 0;
                end
            end
            REQ_READ: begin
                rep.rdata = shadow_regs[r.index];
            end
            REQ_PIO: begin
                if ((shadow_regs[REG_CONFIG] & B_PPIO) != 0) begin
                    if (fill_cnt < BUF_DEPTH_DEF) begin
                        shadow_fifo[wr_ptr] = r.data;
                        fill_cnt++;
                        wr_ptr = (wr_ptr + 1) % BUF_DEPTH_DEF;
                    end else begin
                        drop_cnt++;
                    end
                    ready_f = (fill_cnt <= PIO_THRESHOLD_DEF);
                    if ((shadow_regs[REG_CONFIG] & B_PEN) != 0) begin
                        fmt = shadow_regs[REG_FORMAT];
                        if (fmt[7:5] == FMT_ADPCM) begin
                            bpc = 4;
                        end else begin
                            bpc = 1;
                            if (fmt[7:5] == FMT_16_LE || fmt[7:5] == FMT_16_BE)
                                bpc = bpc * 2;
                            if (fmt[4])
                                bpc = bpc * 2;
                        end
                        base       = {shadow_regs[REG_BASE_HI], shadow_regs[REG_BASE_LO]};
                        period     = (base + 1) * bpc;
                        sample_cnt = (sample_cnt + 1) & 32'h7ffff;
                        if (sample_cnt >= period) begin
                            sample_cnt = 0;
                            shadow_regs[REG_STATUS] = shadow_regs[REG_STATUS] | B_PI;
                            int_f = 1'b1;
                            period_cnt++;
                            if ((shadow_regs[REG_PIN_CTRL] & B_IEN) != 0 && irq_present_f)
                                irq_f = 1'b1;
                        end
                    end
                end
            end
            REQ_DRAIN: begin
                if (fill_cnt > 0) begin
                    rep.rdata  = shadow_fifo[rd_ptr];
                    rd_ptr     = (rd_ptr + 1) % BUF_DEPTH_DEF;
                    fill_cnt--;
                    rep.dvalid = 1'b1;
                    drain_cnt++;
                end
            end
        endcase
        rep.irq  = irq_f;
        rep.intr = int_f;
        rep.prdy = ready_f;
        rep.fill = FILL_W'(fill_cnt);
        if (fill_cnt > peak_fill)
            peak_fill = fill_cnt;
        return rep;
    endfunction

    // request side: accept at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            in_taken = 1'b1;
            reply_q.push_back(codec_apply({t_req_kind'(i_req_type), i_reg_index, i_data_byte}));
        end
    end

    always @(negedge i_clk) begin : request_driver
        t_req cur;
        if (i_rst_n && !(i_valid && !in_taken)) begin
            in_taken = 1'b0;
            if (tx_wait > 0) begin
                tx_wait--;
                i_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                cur = req_q.pop_front();
                i_req_type  <= cur.kind;
                i_reg_index <= cur.index;
                i_data_byte <= cur.data;
                i_valid     <= 1'b1;
                tx_wait = pick_wait(tx_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // reply side
    always @(posedge i_clk) begin : reply_monitor
        t_reply got;
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            out_taken = 1'b1;
            reply_cnt++;
            got = {o_read_data, o_drain_valid, o_irq_line, o_int_status, o_play_ready,
                   o_buffer_fill};
            if (reply_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected reply rd=%02h dv=%0b irq=%0b int=%0b prdy=%0b fill=%0d",
                             got.rdata, got.dvalid, got.irq, got.intr, got.prdy, got.fill);
            end else begin
                want = reply_q.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("reply %0d expected rd=%02h dv=%0b irq=%0b int=%0b prdy=%0b fill=%0d",
                                 reply_cnt, want.rdata, want.dvalid, want.irq, want.intr,
                                 want.prdy, want.fill);
                        $display("reply %0d actual   rd=%02h dv=%0b irq=%0b int=%0b prdy=%0b fill=%0d",
                                 reply_cnt, got.rdata, got.dvalid, got.irq, got.intr,
                                 got.prdy, got.fill);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            rx_wait = pick_wait(rx_calm);
            if (reply_cnt == HOLD_AT)
                hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic push_req(t_req_kind k, logic [4:0] idx, logic [7:0] d);
        t_req r;
        r.kind  = k;
        r.index = idx;
        r.data  = d;
        req_q.push_back(r);
        req_cnt++;
    endtask

    task automatic settle();
        while (req_q.size() != 0 || i_valid || reply_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_irq_present(bit v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        irq_present_f = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic directed_reqs();
        push_req(REQ_READ,  5'd0,        8'h00);
        push_req(REQ_WRITE, REG_TEST,    8'hff);
        push_req(REQ_READ,  REG_TEST,    8'h00);
        push_req(REQ_WRITE, REG_VERSION, 8'hff);
        push_req(REQ_READ,  REG_VERSION, 8'h00);
        push_req(REQ_WRITE, REG_MODE,    8'hff);
        push_req(REQ_READ,  REG_MODE,    8'h00);
        push_req(REQ_WRITE, REG_MODE,    8'h00);
        push_req(REQ_DRAIN, 5'd0,        8'h00);
        push_req(REQ_PIO,   5'd0,        8'h5a);
        push_req(REQ_WRITE, REG_BASE_LO, 8'h01);
        push_req(REQ_WRITE, REG_PIN_CTRL, B_IEN);
        push_req(REQ_WRITE, REG_CONFIG,  B_PPIO | B_PEN);
        push_req(REQ_PIO,   5'd0,        8'h00);
        push_req(REQ_PIO,   5'd31,       8'hff);
        push_req(REQ_DRAIN, 5'd31,       8'hff);
        push_req(REQ_READ,  REG_STATUS,  8'h00);
        push_req(REQ_WRITE, REG_STATUS,  8'hff);
        push_req(REQ_WRITE, REG_STATUS,  8'h00);
        push_req(REQ_PIO,   5'd0,        8'h3c);
        push_req(REQ_WRITE, REG_FORMAT,  8'h50);
        push_req(REQ_DRAIN, 5'd0,        8'h00);
        push_req(REQ_WRITE, 5'd31,       8'hff);
        push_req(REQ_READ,  5'd31,       8'h00);
        push_req(REQ_WRITE, REG_CONFIG,  B_PPIO | B_CEN);
    endtask

    task automatic random_reqs(int unsigned n);
        int unsigned start;
        logic [7:0]  d;
        start = req_cnt;
        while (req_cnt - start < n) begin
            case ($urandom_range(0, 11))
                0: begin
                    push_req(REQ_WRITE, REG_FORMAT, 8'($urandom));
                    push_req(REQ_WRITE, REG_BASE_HI,
                             ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
                    push_req(REQ_WRITE, REG_BASE_LO, 8'($urandom_range(0, 5)));
                    push_req(REQ_WRITE, REG_PIN_CTRL, 8'($urandom));
                    d = 8'($urandom);
                    if ($urandom_range(0, 4) != 0)
                        d = d | B_PPIO | B_PEN;
                    push_req(REQ_WRITE, REG_CONFIG, d);
                end
                1, 2, 3: begin
                    repeat ($urandom_range(1, 40))
                        push_req(REQ_PIO, 5'($urandom), 8'($urandom));
                end
                4, 5: begin
                    repeat ($urandom_range(1, 30))
                        push_req(REQ_DRAIN, 5'($urandom), 8'($urandom));
                end
                6: begin
                    repeat ($urandom_range(1, 4))
                        push_req(REQ_READ, ($urandom_range(0, 1) == 0) ? REG_STATUS
                                                                      : 5'($urandom),
                                 8'($urandom));
                end
                7: begin
                    push_req(REQ_WRITE, REG_STATUS,
                             ($urandom_range(0, 1) == 0) ? ~B_PI : 8'($urandom));
                end
                8: begin
                    push_req(REQ_WRITE, 5'($urandom), 8'($urandom));
                end
                9: begin
                    repeat ($urandom_range(1, 5))
                        push_req(t_req_kind'($urandom_range(0, 3)), 5'($urandom),
                                 8'($urandom));
                end
                10: begin
                    push_req(REQ_WRITE, REG_CONFIG, B_PPIO | 8'($urandom_range(0, 15)));
                end
                default: begin
                    repeat ($urandom_range(4, 30))
                        push_req(($urandom_range(0, 2) == 0) ? REQ_DRAIN : REQ_PIO,
                                 5'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    task automatic pio_burst();
        push_req(REQ_WRITE, REG_FORMAT,   8'h00);
        push_req(REQ_WRITE, REG_BASE_HI,  8'h00);
        push_req(REQ_WRITE, REG_BASE_LO,  8'h03);
        push_req(REQ_WRITE, REG_PIN_CTRL, B_IEN);
        push_req(REQ_WRITE, REG_CONFIG,   B_PPIO | B_PEN);
        repeat (BURST_LEN)
            push_req(REQ_PIO, 5'($urandom), 8'($urandom));
        push_req(REQ_READ,  REG_STATUS, 8'h00);
        repeat (3)
            push_req(REQ_DRAIN, 5'd0, 8'h00);
        push_req(REQ_WRITE, REG_FORMAT, 8'hf0);
        push_req(REQ_DRAIN, 5'd0, 8'h00);
    endtask

    initial begin
        foreach (shadow_regs[i])
            shadow_regs[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_irq_present(1'b1);
        directed_reqs();
        settle();
        set_irq_present(1'b0);
        random_reqs(250);
        settle();
        set_irq_present(1'b1);
        random_reqs(250);
        settle();
        pio_burst();
        settle();
        set_irq_present(1'b0);
        random_reqs(260);
        settle();
        set_irq_present(1'b1);
        random_reqs(250);
        settle();
        repeat (8) @(negedge i_clk);

        $display("%0d requests sent, %0d replies checked, %0d failures",
                 req_cnt, reply_cnt, fail_cnt);
        $display("%0d bytes drained, %0d playback periods, %0d bytes dropped at full, peak fill %0d",
                 drain_cnt, period_cnt, drop_cnt, peak_fill);
        if (fail_cnt == 0 && reply_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
